>>> rtl/core/rcbp_pkg.sv
package rcbp_pkg;

    localparam int FRAME_DEPTH_DEF = 8;
    localparam int MODE_RUN        = 4;

    localparam logic [7:0] DEFAULT_SPEED   = 8'd50;
    localparam logic [7:0] MAX_SPEED_RST   = 8'd100;
    localparam logic [15:0] TIMEOUT_RST    = 16'd3000;

    localparam logic [7:0] FRAME_HEAD      = 8'h50;
    localparam logic [7:0] FRAME_TAIL      = 8'h59;
    localparam logic [7:0] DIR_MAX         = 8'd8;
    localparam logic [7:0] BYTE_TRACK      = 8'h11;
    localparam logic [7:0] BYTE_AVOID      = 8'h22;
    localparam logic [7:0] BYTE_MANUAL     = 8'h33;

    localparam logic REG_MAX_SPEED    = 1'b0;
    localparam logic REG_LINK_TIMEOUT = 1'b1;

    localparam int OUT_BITS = 72;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_TAKE = 2'd2,
        ACT_ACK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_AVOID  = 2'd2
    } car_mode_t;

    typedef struct packed {
        car_mode_t car_mode;
        logic      latched;
        logic      stop;
    } mode_stat_t;

    typedef struct packed {
        logic        ready;
        logic [3:0]  direction;
        logic [7:0]  speed;
        logic [31:0] command_time;
    } cmd_stat_t;

endpackage

>>> rtl/core/rcbp_mode_det.sv
module rcbp_mode_det (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_en,
    input  logic                   ack_en,
    input  logic [7:0]             rx_byte,
    output rcbp_pkg::mode_stat_t   stat
);
    import rcbp_pkg::*;

    logic [7:0] hist_reg  [MODE_RUN];
    logic [7:0] hist_next [MODE_RUN];
    logic [2:0] fill_reg, fill_next;
    car_mode_t  mode_reg, mode_next;
    logic       latch_reg, latch_next;
    logic       stop;
    logic       is_mode;
    car_mode_t  target;
    logic       all_equal;

    always_comb
    begin
        is_mode = 1'b1;
        target  = MODE_MANUAL;
        case (rx_byte)
            BYTE_TRACK:  target = MODE_TRACK;
            BYTE_AVOID:  target = MODE_AVOID;
            BYTE_MANUAL: target = MODE_MANUAL;
            default:     is_mode = 1'b0;
        endcase
    end

    always_comb
    begin
        hist_next  = hist_reg;
        fill_next  = fill_reg;
        mode_next  = mode_reg;
        latch_next = latch_reg;
        stop       = 1'b0;
        all_equal  = 1'b0;
        if (byte_en)
        begin
            if (!is_mode)
            begin
                fill_next = '0;
            end
            else
            begin
                if (fill_reg < 3'(MODE_RUN))
                begin
                    hist_next[fill_reg[1:0]] = rx_byte;
                    fill_next = fill_reg + 3'd1;
                end
                else
                begin
                    for (int i = 0; i < MODE_RUN - 1; i++)
                        hist_next[i] = hist_reg[i + 1];
                    hist_next[MODE_RUN - 1] = rx_byte;
                end
                all_equal = (hist_next[0] == hist_next[1]) && (hist_next[1] == hist_next[2])
                         && (hist_next[2] == hist_next[3]);
                if (fill_next >= 3'(MODE_RUN) && all_equal)
                begin
                    if (target != mode_reg)
                    begin
                        mode_next  = target;
                        latch_next = 1'b1;
                        stop       = 1'b1;
                    end
                    fill_next = '0;
                end
            end
        end
        else if (ack_en)
        begin
            latch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            mode_reg  <= MODE_MANUAL;
            latch_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            mode_reg  <= mode_next;
            latch_reg <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign stat.car_mode = mode_next;
    assign stat.latched  = latch_next;
    assign stat.stop     = stop;

endmodule

>>> rtl/core/rcbp_cmd.sv
module rcbp_cmd #(
    parameter int FRAME_DEPTH = rcbp_pkg::FRAME_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic                 take_en,
    input  logic                 latched,
    input  logic [7:0]           rx_byte,
    input  logic [31:0]          ms_count,
    input  logic [7:0]           max_speed,
    output rcbp_pkg::cmd_stat_t  stat
);
    import rcbp_pkg::*;

    localparam int FW = $clog2(FRAME_DEPTH + 1);

    logic          in_frame_reg, in_frame_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    last_reg, last_next;
    logic [3:0]    dir_reg, dir_next;
    logic [7:0]    speed_reg, speed_next;
    logic          pend_reg, pend_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic          accept;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        last_next     = last_reg;
        dir_next      = dir_reg;
        speed_next    = speed_reg;
        pend_next     = pend_reg;
        stamp_next    = stamp_reg;
        accept        = 1'b0;
        if (byte_en && !latched)
        begin
            if (rx_byte == FRAME_HEAD)
            begin
                in_frame_next = 1'b1;
                fill_next     = '0;
            end
            else if (in_frame_reg)
            begin
                if (rx_byte == FRAME_TAIL)
                begin
                    if (fill_reg != '0 && last_reg <= max_speed)
                    begin
                        speed_next = last_reg;
                        accept     = 1'b1;
                    end
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                end
                else if (fill_reg < FW'(FRAME_DEPTH))
                begin
                    last_next = rx_byte;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                end
            end
            else if (rx_byte <= DIR_MAX)
            begin
                dir_next = rx_byte[3:0];
                accept   = 1'b1;
            end
        end
        else if (take_en)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            pend_next  = 1'b1;
            stamp_next = ms_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            dir_reg      <= '0;
            speed_reg    <= DEFAULT_SPEED;
            pend_reg     <= 1'b0;
            stamp_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            dir_reg      <= dir_next;
            speed_reg    <= speed_next;
            pend_reg     <= pend_next;
            stamp_reg    <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    assign stat.ready        = pend_reg;
    assign stat.direction    = dir_next;
    assign stat.speed        = speed_next;
    assign stat.command_time = stamp_next;

endmodule

>>> rtl/core/remote_command_byte_parser_core.sv
// A request accepted on s_axis is held in the input register, then passes to the result register.
// Throughput: one request per cycle; a stalled result holds s_axis_tready low
// once the input register is full.
// Reset: asynchronous, active low; clears counters, flags and mode, restores max_speed 100,
// link_timeout_ms 3000 and speed 50.
module remote_command_byte_parser_core #(
    parameter int FRAME_DEPTH = rcbp_pkg::FRAME_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] command_ready, [4:1] direction, [12:5] speed, [44:13] command_time,
    // [46:45] car_mode, [47] mode_change_pending, [48] stop_request,
    // [49] link_up, [65:50] byte_count, [71:66] zero
    output logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcbp_pkg::*;

    logic                in_valid_reg;
    action_t             in_action_reg;
    logic [7:0]          in_byte_reg;
    logic                advance;
    logic                byte_en, tick_en, take_en, ack_en;

    logic [7:0]          max_speed_reg;
    logic [15:0]         timeout_reg;
    logic                cfg_wr;

    logic [31:0]         ms_reg, ms_next;
    logic [31:0]         lbt_reg, lbt_next;
    logic                link_reg, link_next;
    logic [15:0]         count_reg, count_next;
    logic [31:0]         elapsed;

    mode_stat_t          mode_stat;
    cmd_stat_t           cmd_stat;

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign byte_en       = advance && (in_action_reg == ACT_BYTE);
    assign tick_en       = advance && (in_action_reg == ACT_TICK);
    assign take_en       = advance && (in_action_reg == ACT_TAKE);
    assign ack_en        = advance && (in_action_reg == ACT_ACK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= action_t'(s_axis_tuser);
            in_byte_reg   <= s_axis_tdata;
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_SPEED:    max_speed_reg <= pwdata[7:0];
                REG_LINK_TIMEOUT: timeout_reg   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_SPEED:    prdata = {24'd0, max_speed_reg};
            REG_LINK_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:          prdata = '0;
        endcase
    end

    rcbp_mode_det u_mode (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .ack_en  (ack_en),
        .rx_byte (in_byte_reg),
        .stat    (mode_stat)
    );

    rcbp_cmd #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_cmd (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .take_en   (take_en),
        .latched   (mode_stat.latched),
        .rx_byte   (in_byte_reg),
        .ms_count  (ms_reg),
        .max_speed (max_speed_reg),
        .stat      (cmd_stat)
    );

    always_comb
    begin
        ms_next    = tick_en ? ms_reg + 32'd1 : ms_reg;
        lbt_next   = byte_en ? ms_reg : lbt_reg;
        count_next = byte_en ? count_reg + 16'd1 : count_reg;
        link_next  = link_reg || byte_en;
        elapsed    = ms_next - lbt_next;
        if (advance && elapsed > {16'd0, timeout_reg})
            link_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg    <= '0;
            lbt_reg   <= '0;
            link_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            ms_reg    <= ms_next;
            lbt_reg   <= lbt_next;
            link_reg  <= link_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {6'd0, count_next, link_next, mode_stat.stop,
                             mode_stat.latched, mode_stat.car_mode,
                             cmd_stat.command_time, cmd_stat.speed,
                             cmd_stat.direction, cmd_stat.ready};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/core/rcbp_chk.sv
module rcbp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    import rcbp_pkg::*;

    logic [3:0] dir;
    logic [1:0] mode;
    logic       pend;
    logic       stop;

    assign dir  = m_axis_tdata[4:1];
    assign mode = m_axis_tdata[46:45];
    assign pend = m_axis_tdata[47];
    assign stop = m_axis_tdata[48];

    a_stop_latched: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && stop |-> pend)
        else $error("stop request without mode latch");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (mode == MODE_MANUAL || mode == MODE_TRACK || mode == MODE_AVOID))
        else $error("car mode out of range");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> dir <= DIR_MAX[3:0])
        else $error("direction out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind remote_command_byte_parser_core rcbp_chk u_rcbp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/rcbp_status_checker.sv
`timescale 1ns / 100ps

module rcbp_status_checker #(
    parameter int FRAME_DEPTH = rcbp_pkg::FRAME_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] command_ready, [4:1] direction, [12:5] speed, [44:13] command_time,
    // [46:45] car_mode, [47] mode_change_pending, [48] stop_request,
    // [49] link_up, [65:50] byte_count, [71:66] zero
    input  logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          awaited,
    output int          mismatches
);
    import rcbp_pkg::*;

    typedef struct packed {
        logic [15:0] byte_count;
        logic        link_up;
        logic        stop_request;
        logic        mode_change_pending;
        car_mode_t   car_mode;
        logic [31:0] command_time;
        logic [7:0]  speed;
        logic [3:0]  direction;
        logic        command_ready;
    } status_t;

    status_t status_awaited[$];

    logic [7:0]  max_speed_r;
    logic [15:0] timeout_r;
    logic [31:0] ms_count;
    logic [31:0] last_rx_ms;
    logic        link_ok;
    logic [15:0] rx_total;
    logic [7:0]  run_hist [4];
    logic [2:0]  run_fill;
    car_mode_t   cur_mode;
    logic        mode_hold;
    logic        in_frame;
    logic [6:0]  frame_fill;
    logic [7:0]  frame_last;
    logic [3:0]  cur_dir;
    logic [7:0]  cur_speed;
    logic        cmd_pending;
    logic [31:0] cmd_stamp;

    initial mismatches = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void reset_parser();
        max_speed_r = MAX_SPEED_RST;
        timeout_r   = TIMEOUT_RST;
        ms_count    = '0;
        last_rx_ms  = '0;
        link_ok     = 1'b0;
        rx_total    = '0;
        run_fill    = '0;
        cur_mode    = MODE_MANUAL;
        mode_hold   = 1'b0;
        in_frame    = 1'b0;
        frame_fill  = '0;
        frame_last  = '0;
        cur_dir     = '0;
        cur_speed   = DEFAULT_SPEED;
        cmd_pending = 1'b0;
        cmd_stamp   = '0;
        for (int i = 0; i < MODE_RUN; i++)
            run_hist[i] = '0;
    endfunction

    function automatic void take_command();
        cmd_pending = 1'b1;
        cmd_stamp   = ms_count;
    endfunction

    function automatic logic mode_match(logic [7:0] b);
        car_mode_t target;
        logic      switched;
        switched = 1'b0;
        case (b)
            BYTE_TRACK:  target = MODE_TRACK;
            BYTE_AVOID:  target = MODE_AVOID;
            BYTE_MANUAL: target = MODE_MANUAL;
            default:
            begin
                run_fill = '0;
                return 1'b0;
            end
        endcase
        if (run_fill < MODE_RUN)
        begin
            run_hist[run_fill[1:0]] = b;
            run_fill++;
        end
        else
        begin
            for (int i = 0; i < MODE_RUN - 1; i++)
                run_hist[i] = run_hist[i + 1];
            run_hist[MODE_RUN - 1] = b;
        end
        if (run_fill >= MODE_RUN && run_hist[0] == run_hist[1] &&
            run_hist[1] == run_hist[2] && run_hist[2] == run_hist[3])
        begin
            if (target != cur_mode)
            begin
                cur_mode  = target;
                mode_hold = 1'b1;
                switched  = 1'b1;
            end
            run_fill = '0;
        end
        return switched;
    endfunction

    function automatic void frame_step(logic [7:0] b);
        if (b == FRAME_TAIL)
        begin
            if (frame_fill >= 1 && frame_last <= max_speed_r)
            begin
                cur_speed = frame_last;
                take_command();
            end
            in_frame   = 1'b0;
            frame_fill = '0;
        end
        else if (frame_fill < FRAME_DEPTH)
        begin
            frame_last = b;
            frame_fill++;
        end
        else
        begin
            in_frame   = 1'b0;
            frame_fill = '0;
        end
    endfunction

    function automatic status_t parse_request(action_t act, logic [7:0] b);
        status_t r;
        logic    was_pending;
        logic    stop;
        was_pending = cmd_pending;
        stop        = 1'b0;
        case (act)
            ACT_BYTE:
            begin
                last_rx_ms = ms_count;
                rx_total   = rx_total + 16'd1;
                link_ok    = 1'b1;
                stop       = mode_match(b);
                if (!mode_hold)
                begin
                    if (b == FRAME_HEAD)
                    begin
                        in_frame   = 1'b1;
                        frame_fill = '0;
                    end
                    else if (in_frame)
                        frame_step(b);
                    else if (b <= DIR_MAX)
                    begin
                        cur_dir = b[3:0];
                        take_command();
                    end
                end
            end
            ACT_TICK: ms_count = ms_count + 32'd1;
            ACT_TAKE: cmd_pending = 1'b0;
            default:  mode_hold = 1'b0;
        endcase
        if (ms_count - last_rx_ms > {16'd0, timeout_r})
            link_ok = 1'b0;
        r.command_ready       = was_pending;
        r.direction           = cur_dir;
        r.speed               = cur_speed;
        r.command_time        = cmd_stamp;
        r.car_mode            = cur_mode;
        r.mode_change_pending = mode_hold;
        r.stop_request        = stop;
        r.link_up             = link_ok;
        r.byte_count          = rx_total;
        return r;
    endfunction

    task automatic check_status(logic [71:0] data);
        status_t got;
        status_t want;
        got = status_t'(data[65:0]);
        if (data[71:66] != '0)
            report_mismatch("pad bits", 32'(data[71:66]), 32'd0);
        if (status_awaited.size() == 0)
        begin
            report_mismatch("unrequested status", data[31:0], 32'd0);
            return;
        end
        want = status_awaited.pop_front();
        if (got.command_ready != want.command_ready)
            report_mismatch("command_ready", 32'(got.command_ready), 32'(want.command_ready));
        if (got.direction != want.direction)
            report_mismatch("direction", 32'(got.direction), 32'(want.direction));
        if (got.speed != want.speed)
            report_mismatch("speed", 32'(got.speed), 32'(want.speed));
        if (got.command_time != want.command_time)
            report_mismatch("command_time", got.command_time, want.command_time);
        if (got.car_mode != want.car_mode)
            report_mismatch("car_mode", 32'(got.car_mode), 32'(want.car_mode));
        if (got.mode_change_pending != want.mode_change_pending)
            report_mismatch("mode_change_pending", 32'(got.mode_change_pending),
                            32'(want.mode_change_pending));
        if (got.stop_request != want.stop_request)
            report_mismatch("stop_request", 32'(got.stop_request), 32'(want.stop_request));
        if (got.link_up != want.link_up)
            report_mismatch("link_up", 32'(got.link_up), 32'(want.link_up));
        if (got.byte_count != want.byte_count)
            report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            status_awaited.delete();
            awaited = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    {REG_MAX_SPEED, 2'b00}:    max_speed_r = pwdata[7:0];
                    {REG_LINK_TIMEOUT, 2'b00}: timeout_r   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_status(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                status_awaited.push_back(parse_request(action_t'(s_axis_tuser), s_axis_tdata));
            awaited = status_awaited.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rcbp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 90;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] command_ready, [4:1] direction, [12:5] speed, [44:13] command_time,
    // [46:45] car_mode, [47] mode_change_pending, [48] stop_request,
    // [49] link_up, [65:50] byte_count, [71:66] zero
    logic [71:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          awaited;
    int          mismatches;
    int          stall_cycles;
    int          sent_in_phase;
    logic [7:0]  cur_max;
    logic        tx_busy;
    logic        tx_burst;
    logic        rx_busy;
    logic        hold_req;

    remote_command_byte_parser_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rcbp_status_checker u_status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .awaited       (awaited),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("remote_command_byte_parser_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        rx_busy       = 1'b1;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap      = 300;
            end
            else
                gap = rx_busy ? $urandom_range(0, 10) : 0;
            if ($urandom_range(0, 15) == 0)
                rx_busy = !rx_busy;
            if (gap > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(action_t act, logic [7:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_busy = !tx_busy;
        gap = (tx_busy && !tx_burst) ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        sent_in_phase++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(ACT_BYTE, b);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_speed(logic [7:0] value);
        logic [31:0] word;
        word    = $urandom;
        cur_max = value;
        apb_write(REG_MAX_SPEED, {word[31:8], value});
    endtask

    task automatic set_link_timeout(logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        apb_write(REG_LINK_TIMEOUT, {word[31:16], value});
    endtask

    task automatic random_burst();
        int         n;
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                send_byte(FRAME_HEAD);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : $urandom_range(0, 3);
                repeat (n)
                begin
                    if ($urandom_range(0, 15) == 0)
                        v = FRAME_HEAD;
                    else if ($urandom_range(0, 2) == 0)
                        v = 8'($urandom);
                    else
                        v = 8'($urandom_range(0, cur_max));
                    send_byte(v);
                end
                if ($urandom_range(0, 7) != 0)
                    send_byte(FRAME_TAIL);
            end
            3, 4:
            begin
                case ($urandom_range(0, 2))
                    0:       v = BYTE_TRACK;
                    1:       v = BYTE_AVOID;
                    default: v = BYTE_MANUAL;
                endcase
                repeat ($urandom_range(2, 5)) send_byte(v);
                if ($urandom_range(0, 3) != 0)
                    send_request(ACT_ACK, 8'($urandom));
            end
            5: send_byte(8'($urandom_range(0, 8)));
            6: repeat ($urandom_range(1, 8)) send_request(ACT_TICK, 8'($urandom));
            7: send_request(ACT_TAKE, 8'($urandom));
            8: send_byte(8'($urandom));
            default: send_request(action_t'($urandom_range(0, 3)), 8'($urandom));
        endcase
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_BYTE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rst_n         = 1'b0;
        stall_cycles  = 0;
        sent_in_phase = 0;
        cur_max       = MAX_SPEED_RST;
        tx_busy       = 1'b1;
        tx_burst      = 1'b0;
        hold_req      = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_byte(8'h00);
        send_byte(DIR_MAX);
        send_byte(8'h09);
        send_byte(8'hFF);
        send_request(ACT_TAKE, 8'h00);
        send_request(ACT_TAKE, 8'hFF);
        send_request(ACT_TICK, 8'hA5);
        send_byte(FRAME_HEAD);
        send_byte(8'h20);
        send_byte(FRAME_TAIL);
        send_byte(FRAME_HEAD);
        send_byte(FRAME_TAIL);
        send_byte(FRAME_HEAD);
        send_byte(8'hFF);
        send_byte(FRAME_TAIL);
        repeat (4) send_byte(BYTE_TRACK);
        send_byte(8'h03);
        send_request(ACT_ACK, 8'h5A);
        repeat (4) send_byte(BYTE_MANUAL);

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                sent_in_phase = 0;
            end
            case (phase)
                1:
                begin
                    set_max_speed(8'hFF);
                    set_link_timeout(16'd0);
                end
                2:
                begin
                    set_max_speed(8'h00);
                    set_link_timeout(16'hFFFF);
                end
                3:
                begin
                    set_max_speed(8'($urandom_range(1, 254)));
                    set_link_timeout(16'd3);
                end
                4:
                begin
                    set_max_speed(8'd60);
                    set_link_timeout(16'($urandom_range(1, 20)));
                end
                default: ;
            endcase
            if (phase == 2)
            begin
                hold_req = 1'b1;
                tx_burst = 1'b1;
                repeat (10) random_burst();
                tx_burst = 1'b0;
            end
            while (sent_in_phase < PHASE_ITEMS)
                random_burst();
        end

        drain_results();
        if (mismatches == 0)
            $display("remote_command_byte_parser_core: match");
        else
            $display("remote_command_byte_parser_core: mismatch");
        $finish;
    end

endmodule
